FILE: rtl/dcrb_pkg.sv
// Package for the display control register block: payload types, codes and tables.
package dcrb_pkg;

    // Control port commands (top byte of the written word)
    localparam logic [7:0] OP_RESET   = 8'h00;
    localparam logic [7:0] OP_BLANK   = 8'h03;
    localparam logic [7:0] OP_DMA     = 8'h04;
    localparam logic [7:0] OP_ORIGIN  = 8'h05;
    localparam logic [7:0] OP_HRANGE  = 8'h06;
    localparam logic [7:0] OP_VRANGE  = 8'h07;
    localparam logic [7:0] OP_MODE    = 8'h08;
    localparam logic [3:0] OP_INFO_HI = 4'h1;

    // Info query selectors
    localparam logic [3:0] INFO_ENV2    = 4'd2;
    localparam logic [3:0] INFO_ENV3    = 4'd3;
    localparam logic [3:0] INFO_ENV4    = 4'd4;
    localparam logic [3:0] INFO_ENV5    = 4'd5;
    localparam logic [3:0] INFO_VERSION = 4'd7;

    localparam logic [31:0] INFO_VERSION_VAL = 32'd2;
    localparam logic [31:0] INFO_MASK_20     = 32'h000F_FFFF;
    localparam logic [31:0] INFO_MASK_22     = 32'h003F_FFFF;

    // Environment words carry top byte E0..E7
    localparam logic [4:0] ENV_TAG = 5'b11100;

    localparam logic [31:0] STATUS_RESET = 32'h1480_2000;
    localparam logic [9:0]  WIDTH_RESET  = 10'd256;
    localparam logic [8:0]  HEIGHT_RESET = 9'd240;

    localparam logic [12:0] HSPAN_FULL     = 13'd2560;
    localparam int          RECIP_SHIFT    = 19;
    localparam int          RECIP_W        = 18;

    typedef struct packed {
        logic        cmd;
        logic [31:0] data_word;
    } item_t;

    typedef struct packed {
        logic [31:0] status_word;
        logic [31:0] info_word;
        logic [9:0]  display_width;
        logic [8:0]  display_height;
        logic [9:0]  origin_x;
        logic [8:0]  origin_y;
    } result_t;

    function automatic logic [31:0] env_reset_value(logic [2:0] idx);
        return {ENV_TAG, idx, 24'h00_0000};
    endfunction

    // Horizontal resolution by status bits 18..16
    function automatic logic [9:0] hres_of(logic [2:0] idx);
        logic [9:0] r;
        case (idx)
            3'd0:    r = 10'd256;
            3'd1:    r = 10'd368;
            3'd2:    r = 10'd320;
            3'd3:    r = 10'd384;
            3'd4:    r = 10'd512;
            3'd5:    r = 10'd512;
            3'd6:    r = 10'd640;
            default: r = 10'd640;
        endcase
        return r;
    endfunction

    // ceil(hres * 2^19 / 2560): exact floor(span * hres / 2560) for span < 2560
    function automatic logic [RECIP_W-1:0] hres_recip(logic [2:0] idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            3'd0:    r = 18'd52429;
            3'd1:    r = 18'd75367;
            3'd2:    r = 18'd65536;
            3'd3:    r = 18'd78644;
            3'd4:    r = 18'd104858;
            3'd5:    r = 18'd104858;
            3'd6:    r = 18'd131072;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

    // Vertical resolution by status bits 20..19
    function automatic logic [8:0] vres_of(logic [1:0] idx);
        logic [8:0] r;
        case (idx)
            2'd0:    r = 9'd240;
            2'd1:    r = 9'd480;
            2'd2:    r = 9'd256;
            default: r = 9'd480;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/display_control_register_block_top.sv
// Top level of the display control register block: decode, state and result registers.
//
//  channel  | valid         | stall         | payload              | direction
//  ---------+---------------+---------------+----------------------+----------
//  item     | item_valid    | item_stall    | item   (item_t)      | in
//  result   | result_valid  | result_stall  | result (result_t)    | out
//
// One result per item. An item is held in the input register, then decoded and
// applied to the state on the way into the result register; throughput is one item
// per cycle while the result side does not stall, set by the single decode/update path
// and its one 12x18 multiply for the width scale.
// Reset clears the state to its power-on values asynchronously; no clearing pass.
// A stalled result holds in the result register while the input register still takes
// one more transaction; item_stall rises only while both registers are full.
module display_control_register_block_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  dcrb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output dcrb_pkg::result_t result
);
    import dcrb_pkg::*;

    // Input and result stages
    logic    in_valid_reg;
    item_t   in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    fire;

    // Block state
    logic [31:0] status_reg, status_next;
    logic [31:0] env_reg [8];
    logic [31:0] env_next [8];
    logic [31:0] info_reg, info_next;
    logic [9:0]  org_x_reg, org_x_next;
    logic [8:0]  org_y_reg, org_y_next;
    logic [11:0] hstart_reg, hstart_next;
    logic [11:0] hend_reg, hend_next;
    logic [9:0]  vstart_reg, vstart_next;
    logic [9:0]  vend_reg, vend_next;
    logic [9:0]  width_reg, width_next;
    logic [8:0]  height_reg, height_next;

    // Decode and derived values
    logic [7:0]  op;
    logic [31:0] d;
    logic [9:0]  hres;
    logic [8:0]  vres;
    logic [12:0] h_span;
    logic [29:0] w_prod;
    logic [9:0]  width_calc;
    logic [10:0] v_span;
    logic [11:0] v_span2;
    logic [8:0]  height_calc;

    // Advance the input stage when the result register is free or being drained
    assign fire         = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall   = in_valid_reg && !fire;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign op = in_reg.data_word[31:24];
    assign d  = in_reg.data_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                in_valid_reg <= item_valid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_reg <= item;
        if (fire)
        begin
            out_reg.status_word    <= status_next;
            out_reg.info_word      <= info_next;
            out_reg.display_width  <= width_next;
            out_reg.display_height <= height_next;
            out_reg.origin_x       <= org_x_next;
            out_reg.origin_y       <= org_y_next;
        end
    end

    // Width and height from the next ranges and the next display mode
    always_comb
    begin
        hres   = hres_of(status_next[18:16]);
        vres   = vres_of(status_next[20:19]);
        h_span = {1'b0, hend_next} - {1'b0, hstart_next};
        w_prod = 30'(h_span[11:0]) * 30'(hres_recip(status_next[18:16]));
        if (h_span[12] || (h_span == 13'd0) || (h_span >= HSPAN_FULL))
            width_calc = hres;
        else
            width_calc = w_prod[RECIP_SHIFT+9:RECIP_SHIFT];

        v_span  = {1'b0, vend_next} - {1'b0, vstart_next};
        v_span2 = status_next[19] ? {v_span, 1'b0} : {v_span[10], v_span};
        if (v_span2[11] || (v_span2 == 12'd0) || (v_span2 > {3'b000, vres}))
            height_calc = vres;
        else
            height_calc = v_span2[8:0];
    end

    always_comb
    begin
        status_next = status_reg;
        env_next    = env_reg;
        info_next   = info_reg;
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        hstart_next = hstart_reg;
        hend_next   = hend_reg;
        vstart_next = vstart_reg;
        vend_next   = vend_reg;
        width_next  = width_reg;
        height_next = height_reg;

        if (in_reg.cmd)
        begin
            // Store drawing-environment word, refresh low status bits
            if (op[7:3] == ENV_TAG)
            begin
                env_next[op[2:0]] = d;
                status_next[12:0] = {env_next[6][1:0], env_next[1][10:0]};
            end
        end
        else
        begin
            case (op)
                OP_RESET:
                begin
                    for (int i = 0; i < 8; i++)
                        env_next[i] = env_reset_value(3'(i));
                    status_next = STATUS_RESET;
                    info_next   = 32'd0;
                    width_next  = WIDTH_RESET;
                    height_next = HEIGHT_RESET;
                end
                OP_BLANK:
                    status_next[23] = d[0];
                OP_DMA:
                    status_next[30:29] = d[1:0];
                OP_ORIGIN:
                begin
                    org_x_next = d[9:0];
                    org_y_next = d[18:10];
                end
                OP_HRANGE:
                begin
                    hstart_next = d[11:0];
                    hend_next   = d[23:12];
                    width_next  = width_calc;
                end
                OP_VRANGE:
                begin
                    vstart_next = d[9:0];
                    vend_next   = d[19:10];
                    height_next = height_calc;
                end
                OP_MODE:
                begin
                    status_next[22:17] = d[5:0];
                    status_next[16]    = d[6];
                    width_next         = width_calc;
                    height_next        = height_calc;
                end
                default:
                begin
                    if (op[7:4] == OP_INFO_HI)
                    begin
                        case (d[3:0])
                            INFO_ENV2:    info_next = env_reg[2] & INFO_MASK_20;
                            INFO_ENV3:    info_next = env_reg[3] & INFO_MASK_20;
                            INFO_ENV4:    info_next = env_reg[4] & INFO_MASK_20;
                            INFO_ENV5:    info_next = env_reg[5] & INFO_MASK_22;
                            INFO_VERSION: info_next = INFO_VERSION_VAL;
                            default:      info_next = info_reg;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= STATUS_RESET;
            for (int i = 0; i < 8; i++)
                env_reg[i] <= env_reset_value(3'(i));
            info_reg   <= 32'd0;
            org_x_reg  <= 10'd0;
            org_y_reg  <= 9'd0;
            hstart_reg <= 12'd0;
            hend_reg   <= 12'd0;
            vstart_reg <= 10'd0;
            vend_reg   <= 10'd0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (fire)
        begin
            status_reg <= status_next;
            env_reg    <= env_next;
            info_reg   <= info_next;
            org_x_reg  <= org_x_next;
            org_y_reg  <= org_y_next;
            hstart_reg <= hstart_next;
            hend_reg   <= hend_next;
            vstart_reg <= vstart_next;
            vend_reg   <= vend_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // A decoded transaction lands in the result register with the new status
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg && (out_reg.status_word == status_reg))
        else $error("result register missed a decoded transaction");

    // Low status bits always mirror environment words 1 and 6
    a_env_status: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg[10:0] == env_reg[1][10:0]) && (status_reg[12:11] == env_reg[6][1:0]))
        else $error("status low bits out of step with environment words");

    // Effective size never exceeds the current resolution
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg <= hres_of(status_reg[18:16])) &&
        (height_reg <= vres_of(status_reg[20:19])))
        else $error("display size exceeds resolution");

    // Hold the input side only while a finished result is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_valid_reg && out_valid_reg && result_stall))
        else $error("input stalled without a stalled result");

endmodule

FILE: test/dcrb_checker.sv
// Checker for the display control register block: predicts each result and compares.
`timescale 1ns / 100ps

module dcrb_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  dcrb_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  dcrb_pkg::result_t result,
    output int                errors,
    output int                pending
);
    import dcrb_pkg::*;

    localparam logic [7:0][9:0] H_RES = {10'd640, 10'd640, 10'd512, 10'd512,
                                         10'd384, 10'd320, 10'd368, 10'd256};
    localparam logic [3:0][8:0] V_RES = {9'd480, 9'd256, 9'd480, 9'd240};
    localparam int              H_SCALE = 2560;

    // Predicted register state
    logic [31:0] status_q;
    logic [31:0] env_word [0:7];
    logic [31:0] info_q;
    logic [9:0]  org_x_q;
    logic [8:0]  org_y_q;
    logic [11:0] h_start;
    logic [11:0] h_end;
    logic [9:0]  v_start;
    logic [9:0]  v_end;
    logic [9:0]  hres_q;
    logic [9:0]  width_q;
    logic [8:0]  vres_q;
    logic [8:0]  height_q;

    result_t expected_display [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic restore_defaults();
        for (int i = 0; i < 8; i++)
        begin
            env_word[i] = {ENV_TAG, 3'(i), 24'h00_0000};
        end
        status_q = STATUS_RESET;
        info_q   = '0;
        hres_q   = WIDTH_RESET;
        width_q  = WIDTH_RESET;
        vres_q   = HEIGHT_RESET;
        height_q = HEIGHT_RESET;
    endtask

    task automatic rescale_width();
        int span;
        span = int'(h_end) - int'(h_start);
        if (span <= 0 || span >= H_SCALE)
        begin
            width_q = hres_q;
        end
        else
        begin
            width_q = 10'((span * int'(hres_q)) / H_SCALE);
        end
    endtask

    task automatic rescale_height();
        int span;
        span = int'(v_end) - int'(v_start);
        if (status_q[19])
        begin
            span = span * 2;
        end
        if (span <= 0 || span > int'(vres_q))
        begin
            height_q = vres_q;
        end
        else
        begin
            height_q = 9'(span);
        end
    endtask

    // Apply one written word to the predicted state and return the register view after it.
    task automatic apply_display_word(input item_t it, output result_t view);
        logic [31:0] d;
        d = it.data_word;
        if (it.cmd)
        begin
            if (d[31:27] == ENV_TAG)
            begin
                env_word[d[26:24]] = d;
                status_q[12:0] = {env_word[6][1:0], env_word[1][10:0]};
            end
        end
        else
        begin
            case (d[31:24])
                OP_RESET:  restore_defaults();
                OP_BLANK:  status_q[23] = d[0];
                OP_DMA:    status_q[30:29] = d[1:0];
                OP_ORIGIN:
                begin
                    org_x_q = d[9:0];
                    org_y_q = d[18:10];
                end
                OP_HRANGE:
                begin
                    h_start = d[11:0];
                    h_end   = d[23:12];
                    rescale_width();
                end
                OP_VRANGE:
                begin
                    v_start = d[9:0];
                    v_end   = d[19:10];
                    rescale_height();
                end
                OP_MODE:
                begin
                    status_q[22:17] = d[5:0];
                    status_q[16]    = d[6];
                    hres_q = H_RES[status_q[18:16]];
                    vres_q = V_RES[status_q[20:19]];
                    rescale_width();
                    rescale_height();
                end
                default:
                begin
                    if (d[31:28] == OP_INFO_HI)
                    begin
                        case (d[3:0])
                            INFO_ENV2, INFO_ENV3, INFO_ENV4:
                                info_q = env_word[d[2:0]] & INFO_MASK_20;
                            INFO_ENV5:    info_q = env_word[5] & INFO_MASK_22;
                            INFO_VERSION: info_q = INFO_VERSION_VAL;
                            default:      ;
                        endcase
                    end
                end
            endcase
        end
        view.status_word    = status_q;
        view.info_word      = info_q;
        view.display_width  = width_q;
        view.display_height = height_q;
        view.origin_x       = org_x_q;
        view.origin_y       = org_y_q;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t view;
        if (!rst_n)
        begin
            restore_defaults();
            org_x_q = '0;
            org_y_q = '0;
            h_start = '0;
            h_end   = '0;
            v_start = '0;
            v_end   = '0;
            expected_display.delete();
            pending <= 0;
        end
        else
        begin
            // A result at this edge always belongs to an earlier transaction.
            if (result_valid && !result_stall)
            begin
                if (expected_display.size() == 0)
                begin
                    $display("%0t: unexpected result expected none, got %h", $time, result);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_display.pop_front();
                    check_field("status_word", want.status_word, result.status_word);
                    check_field("info_word", want.info_word, result.info_word);
                    check_field("display_width", 32'(want.display_width),
                                32'(result.display_width));
                    check_field("display_height", 32'(want.display_height),
                                32'(result.display_height));
                    check_field("origin_x", 32'(want.origin_x), 32'(result.origin_x));
                    check_field("origin_y", 32'(want.origin_y), 32'(result.origin_y));
                end
            end
            if (item_valid && !item_stall)
            begin
                apply_display_word(item, view);
                expected_display.push_back(view);
            end
            pending <= expected_display.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top for the display control register block: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;
    import dcrb_pkg::*;

    localparam int ITEM_TARGET = 500;   // random transactions to send, noise included
    localparam int IDLE_PCT    = 10;    // idle chance per word and stall chance per cycle, in percent
    localparam int STUCK_LIMIT = 1000;  // cycles without any transaction before giving up
    localparam int TAIL_CYCLES = 8;     // settle time after the last expected result

    // Control bytes and info selectors that the block must ignore
    localparam logic [7:0] OP_UNUSED_LO = 8'h01;
    localparam logic [7:0] OP_UNUSED_HI = 8'hFF;
    localparam logic [3:0] INFO_UNUSED  = 4'hF;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int      errors;
    int      pending;
    bit      calm = 1'b0;   // set during the stretch where neither side idles
    int      stuck;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    display_control_register_block_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    dcrb_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    // Stall the result channel at random, except during the calm stretch.
    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: give up once no transaction has moved on either channel for too long.
    initial
    begin
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                stuck = 0;
            else
                stuck = stuck + 1;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Send one word and hold it until the block takes the transaction.
    // Optionally drop valid first, so gaps land at any phase.
    task automatic send_word(input logic cmd, input logic [31:0] data);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item       <= '{cmd: cmd, data_word: data};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    initial
    begin
        int effective;
        int pick;
        int lo;
        int hi;
        logic [3:0] sel;

        // Hold reset, then release it once.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: environment words with all-ones and mixed content.
        send_word(1'b1, {ENV_TAG, 3'd1, 24'hFF_FFFF});
        send_word(1'b1, {ENV_TAG, 3'd6, 24'hFF_FFFF});
        send_word(1'b1, {ENV_TAG, 3'd2, 24'hAB_CDEF});
        send_word(1'b1, {ENV_TAG, 3'd3, 24'h12_3456});
        send_word(1'b1, {ENV_TAG, 3'd4, 24'hF0_F0F0});
        send_word(1'b1, {ENV_TAG, 3'd5, 24'hFF_FFFF});
        send_word(1'b1, {ENV_TAG, 3'd0, 24'h00_0000});
        // Command-port words outside the environment range: ignored.
        send_word(1'b1, 32'hFFFF_FFFF);
        // Info queries, including a selector with no effect.
        send_word(1'b0, {OP_INFO_HI, 4'hF, 20'hF_FFF0, INFO_ENV2});
        send_word(1'b0, {OP_INFO_HI, 4'h0, 20'h0_0000, INFO_ENV3});
        send_word(1'b0, {OP_INFO_HI, 4'hA, 20'h5_5550, INFO_ENV4});
        send_word(1'b0, {OP_INFO_HI, 4'h5, 20'hA_AAA0, INFO_ENV5});
        send_word(1'b0, {OP_INFO_HI, 4'hF, 20'hF_FFF0, INFO_VERSION});
        send_word(1'b0, {OP_INFO_HI, 4'hF, 20'hF_FFF0, INFO_UNUSED});
        // Blanking, DMA mode and origin at their extremes.
        send_word(1'b0, {OP_BLANK, 24'hFF_FFFF});
        send_word(1'b0, {OP_DMA, 24'hFF_FFFF});
        send_word(1'b0, {OP_ORIGIN, 24'hFF_FFFF});
        // Widest mode with double height, then horizontal span edges.
        send_word(1'b0, {OP_MODE, 24'h00_007F});
        send_word(1'b0, {OP_HRANGE, 12'hA00, 12'h000});
        send_word(1'b0, {OP_HRANGE, 12'h9FF, 12'h000});
        send_word(1'b0, {OP_HRANGE, 12'h000, 12'hFFF});
        // Vertical span doubled to exactly the limit, then a span one longer, past it.
        send_word(1'b0, {OP_VRANGE, 4'h0, 10'd240, 10'd0});
        send_word(1'b0, {OP_VRANGE, 4'hF, 10'd241, 10'd0});
        // Unused control bytes, then a soft reset and a cleared mode.
        send_word(1'b0, {OP_UNUSED_LO, 24'hFF_FFFF});
        send_word(1'b0, {OP_UNUSED_HI, 24'hFF_FFFF});
        send_word(1'b0, {OP_RESET, 24'hFF_FFFF});
        send_word(1'b0, {OP_MODE, 24'h00_0000});

        // Random: mostly meaningful words with random content, some noise.
        effective = 0;
        while (effective < ITEM_TARGET)
        begin
            calm = (effective >= 200 && effective < 300);
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                send_word(1'b1, {ENV_TAG, 3'($urandom_range(0, 7)), 24'($urandom)});
                effective = effective + 1;
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 9))
                    0: send_word(1'b0, {OP_BLANK, 24'($urandom)});
                    1: send_word(1'b0, {OP_DMA, 24'($urandom)});
                    2, 9: send_word(1'b0, {OP_ORIGIN, 24'($urandom)});
                    3:
                    begin
                        // Half fully random, half spans around the full-scale edge.
                        if ($urandom_range(0, 1) == 0)
                        begin
                            lo = $urandom_range(0, 4095);
                            hi = $urandom_range(0, 4095);
                        end
                        else
                        begin
                            lo = $urandom_range(0, 1500);
                            hi = lo + $urandom_range(0, 2600);
                            if (hi > 4095)
                                hi = 4095;
                        end
                        send_word(1'b0, {OP_HRANGE, 12'(hi), 12'(lo)});
                    end
                    4:
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            lo = $urandom_range(0, 1023);
                            hi = $urandom_range(0, 1023);
                        end
                        else
                        begin
                            lo = $urandom_range(0, 600);
                            hi = lo + $urandom_range(0, 520);
                            if (hi > 1023)
                                hi = 1023;
                        end
                        send_word(1'b0, {OP_VRANGE, 4'($urandom), 10'(hi), 10'(lo)});
                    end
                    5: send_word(1'b0, {OP_MODE, 24'($urandom)});
                    6, 7:
                    begin
                        // Bias selectors toward the ones that load the info word.
                        if ($urandom_range(0, 1) == 0)
                            sel = 4'($urandom_range(0, 7));
                        else
                            sel = 4'($urandom);
                        send_word(1'b0, {OP_INFO_HI, 4'($urandom), 20'($urandom), sel});
                    end
                    default:
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_word(1'b0, {OP_RESET, 24'($urandom)});
                        else
                            send_word(1'b0, {OP_MODE, 24'($urandom)});
                    end
                endcase
                effective = effective + 1;
            end
            else
            begin
                // Noise: any word on either port.
                send_word(1'($urandom), 32'($urandom));
                effective = effective + 1;
            end
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        // Drain: let the last transaction register, wait for every result, then settle.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
